// ===== hdl/k_nearest_point_selector_core_macros.svh =====
// Assertion helpers for the nearest point selector.
`ifndef K_NEAREST_POINT_SELECTOR_CORE_MACROS_SVH
`define K_NEAREST_POINT_SELECTOR_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define KNP_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define KNP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/knp_pkg.sv =====
`default_nettype none

package knp_pkg;

  // Fixed field widths of the result word
  localparam int DIST_W  = 42;
  localparam int IDX_W   = 12;
  localparam int RANK_W  = 4;
  localparam int FOUND_W = 5;
  localparam int WANT_W  = 5;

  localparam logic [WANT_W-1:0] WANT_RESET = 5'd8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic sum_en;     // add the squared axis terms
    logic insert_en;  // update the sorted slot list
    logic out_load;   // load one slot into the output register
    logic out_last;   // the loaded slot closes the run
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_mark;  // accepted word carried the last point mark
    logic out_full;   // output register holds a word not yet taken
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/k_nearest_point_selector_core.sv =====
// Nearest point selector.
// Input channel (in_valid / in_stall): one word per candidate point, carrying
// the query and the point in signed Q16.4. first_point clears the list and the
// point numbering; last_point asks for the report after this point.
// Each input word passes through squares, sum and list insert, and a new word
// is taken only when the last one is through; in_stall is high while a word is
// at work or a report is going out. The slot list updates all slots together.
// Output channel (out_valid / out_stall): after a word marked last_point, one
// word per slot, rank 0 first, as many as the clamped count_wanted; the first
// enters the output register after the insert step, then one per cycle unless stalled.
// When the receiver stalls the output word holds and the report pauses.
// Configuration channel (cfg_valid / cfg_ready): writes count_wanted, taken in
// any cycle; 0 acts as 1 and values above MAX_KEEP as MAX_KEEP.
// Reset: the list is empty, counters and the overflow flag are zero and
// count_wanted is 8.
`default_nettype none

module k_nearest_point_selector_core
  import knp_pkg::*;
#(
  parameter int COORD_BITS = 20,
  parameter int MAX_KEEP   = 16,
  parameter int MAX_NODES  = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [WANT_W-1:0]            count_wanted,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] query_z,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                         first_point,
  input  logic                         last_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [RANK_W-1:0]            rank,
  output logic [IDX_W-1:0]             point_index,
  output logic [DIST_W-1:0]            distance_sq,
  output logic                         slot_valid,
  output logic [FOUND_W-1:0]           found_count,
  output logic                         too_many_points,
  output logic                         last_result
);

  localparam int KW = $clog2(MAX_KEEP + 1);
  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [IW-1:0] emit_idx;
  logic [KW-1:0] k_eff;

  assign cfg_ready = 1'b1;

  knp_ctrl #(
    .MAX_KEEP (MAX_KEEP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .k_eff     (k_eff),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .emit_idx  (emit_idx)
  );

  knp_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_KEEP   (MAX_KEEP),
    .MAX_NODES  (MAX_NODES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .emit_idx        (emit_idx),
    .status          (status),
    .k_eff           (k_eff),
    .cfg_valid       (cfg_valid),
    .count_wanted    (count_wanted),
    .query_x         (query_x),
    .query_y         (query_y),
    .query_z         (query_z),
    .point_x         (point_x),
    .point_y         (point_y),
    .point_z         (point_z),
    .first_point     (first_point),
    .last_point      (last_point),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .rank            (rank),
    .point_index     (point_index),
    .distance_sq     (distance_sq),
    .slot_valid      (slot_valid),
    .found_count     (found_count),
    .too_many_points (too_many_points),
    .last_result     (last_result)
  );

endmodule

`default_nettype wire

// ===== hdl/knp_ctrl.sv =====
`default_nettype none

module knp_ctrl
  import knp_pkg::*;
#(
  parameter int MAX_KEEP = 16,
  localparam int KW = $clog2(MAX_KEEP + 1),
  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_stall,
  input  status_t       status,
  input  logic [KW-1:0] k_eff,
  output logic          in_stall,
  output cmd_t          cmd,
  output logic [IW-1:0] emit_idx
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [KW:0]   idx_plus;
  logic          idx_last;
  logic          load;

  // Detect the final slot of the report
  assign idx_plus = (KW + 1)'(emit_idx) + 1'b1;
  assign idx_last = (idx_plus == {1'b0, k_eff});
  assign load     = (state == S_EMIT) && (!status.out_full || !out_stall);

  assign in_stall = (state != S_IDLE);

  // Drive datapath commands
  always_comb begin
    cmd.take      = (state == S_IDLE) && in_valid;
    cmd.sum_en    = (state == S_SUM);
    cmd.insert_en = (state == S_INS);
    cmd.out_load  = load;
    cmd.out_last  = idx_last;
  end

  // Sequence one word: squares, sum, insert, then report if marked last
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SUM;
      S_SUM:  state_next = S_INS;
      S_INS:  state_next = status.last_mark ? S_EMIT : S_IDLE;
      S_EMIT: if (load && idx_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_INS) begin
        emit_idx <= '0;
      end else if (load) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/knp_datapath.sv =====
`default_nettype none

module knp_datapath
  import knp_pkg::*;
#(
  parameter int COORD_BITS = 20,
  parameter int MAX_KEEP   = 16,
  parameter int MAX_NODES  = 4096,
  localparam int KW = $clog2(MAX_KEEP + 1),
  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic [IW-1:0]                emit_idx,
  output status_t                      status,
  output logic [KW-1:0]                k_eff,
  input  logic                         cfg_valid,
  input  logic [WANT_W-1:0]            count_wanted,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] query_z,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                         first_point,
  input  logic                         last_point,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [RANK_W-1:0]            rank,
  output logic [IDX_W-1:0]             point_index,
  output logic [DIST_W-1:0]            distance_sq,
  output logic                         slot_valid,
  output logic [FOUND_W-1:0]           found_count,
  output logic                         too_many_points,
  output logic                         last_result
);

  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int SUM_W = SQ_W + 2;
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [WANT_W-1:0]             wanted;
  logic signed [COORD_BITS:0]    dx, dy, dz;
  logic signed [2*COORD_BITS+1:0] px, py, pz;
  logic [SQ_W-1:0]               sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]              sum;
  logic [SUM_W+DIST_W-1:0]       sum_ext;
  logic [DIST_W-1:0]             cand_dist;
  logic                          last_mark;

  logic [DIST_W-1:0]             slot_dist  [MAX_KEEP];
  logic [IDX_W-1:0]              slot_point [MAX_KEEP];
  logic [MAX_KEEP-1:0]           slot_full;
  logic [DIST_W-1:0]             up_dist    [MAX_KEEP];
  logic [IDX_W-1:0]              up_point   [MAX_KEEP];
  logic [MAX_KEEP-1:0]           up_full;

  logic [KW-1:0]                 insert_count;
  logic [KW:0]                   ins_inc;
  logic [KW-1:0]                 found;
  logic [CNT_W-1:0]              point_counter;
  logic [CNT_W+IDX_W-1:0]        cnt_wide;
  logic [IDX_W-1:0]              new_point;
  logic                          overflow_seen;
  logic                          at_limit;
  logic                          clear;

  logic [MAX_KEEP-1:0]           in_k, lt, ahead, hit, shift;
  logic                          do_insert;
  logic [IW+RANK_W-1:0]          rank_wide;

  // Hold the count register; clamp it to the usable slot range
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted <= WANT_RESET;
    end else if (cfg_valid) begin
      wanted <= count_wanted;
    end
  end

  always_comb begin
    if (wanted == '0) begin
      k_eff = KW'(1);
    end else if (wanted > WANT_W'(MAX_KEEP)) begin
      k_eff = KW'(MAX_KEEP);
    end else begin
      k_eff = wanted[KW-1:0];
    end
  end

  // Square the axis differences on the accepted word
  assign dx = (COORD_BITS + 1)'(query_x) - (COORD_BITS + 1)'(point_x);
  assign dy = (COORD_BITS + 1)'(query_y) - (COORD_BITS + 1)'(point_y);
  assign dz = (COORD_BITS + 1)'(query_z) - (COORD_BITS + 1)'(point_z);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_x      <= px[SQ_W-1:0];
      sq_y      <= py[SQ_W-1:0];
      sq_z      <= pz[SQ_W-1:0];
      last_mark <= last_point;
    end
  end

  // Add the terms and saturate to the distance field
  assign sum     = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign sum_ext = {{DIST_W{1'b0}}, sum};

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      cand_dist <= (|sum_ext[SUM_W+DIST_W-1:DIST_W]) ? '1 : sum_ext[DIST_W-1:0];
    end
  end

  // Find the first slot that is empty or strictly farther
  always_comb begin
    for (int s = 0; s < MAX_KEEP; s++) begin
      in_k[s] = (KW'(s) < k_eff);
      lt[s]   = in_k[s] && (!slot_full[s] || (cand_dist < slot_dist[s]));
    end
    for (int s = 0; s < MAX_KEEP; s++) begin
      ahead[s] = |(lt & MAX_KEEP'((1 << s) - 1));
      hit[s]   = lt[s] && !ahead[s];
      shift[s] = in_k[s] && ahead[s];
    end
  end

  assign cnt_wide  = {{IDX_W{1'b0}}, point_counter};
  assign new_point = cnt_wide[IDX_W-1:0];
  assign at_limit  = (point_counter == CNT_W'(MAX_NODES));
  assign do_insert = cmd.insert_en && !at_limit && (cand_dist != '0) && (|lt);
  assign clear     = cmd.take && first_point;

  // Source of each slot when the list shifts down
  for (genvar s = 0; s < MAX_KEEP; s++) begin : g_up
    if (s == 0) begin : g_head
      assign up_dist[s]  = cand_dist;
      assign up_point[s] = new_point;
      assign up_full[s]  = 1'b1;
    end else begin : g_tail
      assign up_dist[s]  = slot_dist[s-1];
      assign up_point[s] = slot_point[s-1];
      assign up_full[s]  = slot_full[s-1];
    end
  end

  // Insert the new point and shift the farther slots down
  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int s = 0; s < MAX_KEEP; s++) begin
        if (hit[s]) begin
          slot_dist[s]  <= cand_dist;
          slot_point[s] <= new_point;
        end else if (shift[s]) begin
          slot_dist[s]  <= up_dist[s];
          slot_point[s] <= up_point[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      slot_full <= '0;
    end else if (do_insert) begin
      for (int s = 0; s < MAX_KEEP; s++) begin
        if (hit[s]) begin
          slot_full[s] <= 1'b1;
        end else if (shift[s]) begin
          slot_full[s] <= up_full[s];
        end
      end
    end
  end

  // Count insertions and points; flag points past the limit
  assign ins_inc = (KW + 1)'(insert_count) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      insert_count  <= '0;
      point_counter <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.insert_en) begin
      if (at_limit) begin
        overflow_seen <= 1'b1;
      end else begin
        point_counter <= point_counter + 1'b1;
      end
      if (do_insert) begin
        insert_count <= (ins_inc > {1'b0, k_eff}) ? k_eff : ins_inc[KW-1:0];
      end
    end
  end

  // Load one slot into the output register
  assign found     = (insert_count < k_eff) ? insert_count : k_eff;
  assign rank_wide = {{RANK_W{1'b0}}, emit_idx};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rank            <= rank_wide[RANK_W-1:0];
      point_index     <= slot_full[emit_idx] ? slot_point[emit_idx] : '0;
      distance_sq     <= slot_full[emit_idx] ? slot_dist[emit_idx] : '0;
      slot_valid      <= slot_full[emit_idx];
      found_count     <= FOUND_W'(found);
      too_many_points <= overflow_seen;
      last_result     <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_full  = out_valid;
  assign status.last_mark = last_mark;

endmodule

`default_nettype wire

// ===== hdl/knp_checker.sv =====
`default_nettype none

`include "k_nearest_point_selector_core_macros.svh"

module knp_checker
  import knp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [RANK_W-1:0]   rank,
  input logic [IDX_W-1:0]    point_index,
  input logic [DIST_W-1:0]   distance_sq,
  input logic                slot_valid,
  input logic [FOUND_W-1:0]  found_count,
  input logic                last_result
);

  // A stalled result word holds
  `KNP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(rank) && $stable(point_index) && $stable(distance_sq), "stalled result word changed")

  // Report words follow each other in rank order without gaps
  `KNP_ASSERT_NEXT(a_rank_step, clk, rst, out_valid && !out_stall && !last_result, out_valid && (rank == RANK_W'($past(rank) + 1'b1)), "report word missing or out of order")

  // An accepted point keeps the input closed for the next cycle
  `KNP_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && !in_stall, in_stall, "input taken while a point is at work")

  // A filled slot implies at least one insertion was counted
  `KNP_ASSERT_SAME(a_found_nonzero, clk, rst, out_valid && slot_valid, found_count != '0, "filled slot with zero found count")

endmodule

bind k_nearest_point_selector_core knp_checker u_knp_checker (.*);

`default_nettype wire

// ===== sim/k_nearest_point_selector_core_test.sv =====
`default_nettype none

module k_nearest_point_selector_core_test;
  import knp_pkg::*;

  localparam int COORD_W = 20;
  localparam int KEEP_MAX = 16;
  localparam int NODE_LIMIT = 4096;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_CYCLES = 20;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF = 300;
  localparam logic [DIST_W-1:0] SQ_EMPTY = '1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MAX = 20'sh7FFFF;
  localparam coord_t C_MIN = 20'sh80000;

  typedef struct {
    coord_t qx, qy, qz;
    coord_t px, py, pz;
    bit     first;
    bit     last;
  } point_t;

  typedef struct {
    logic [RANK_W-1:0]  rank;
    logic [IDX_W-1:0]   idx;
    logic [DIST_W-1:0]  sq;
    bit                 full;
    logic [FOUND_W-1:0] found;
    bit                 over;
    bit                 last;
  } slot_report_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WANT_W-1:0] count_wanted = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t query_x = '0, query_y = '0, query_z = '0;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  logic first_point = 1'b0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RANK_W-1:0] rank;
  logic [IDX_W-1:0] point_index;
  logic [DIST_W-1:0] distance_sq;
  logic slot_valid;
  logic [FOUND_W-1:0] found_count;
  logic too_many_points;
  logic last_result;

  // Sorted-list mirror and run counters
  logic [DIST_W-1:0] slot_sq [KEEP_MAX];
  logic [IDX_W-1:0] slot_idx [KEEP_MAX];
  bit slot_full [KEEP_MAX];
  int unsigned insert_cnt;
  int unsigned point_cnt;
  bit overflow_flag;
  logic [WANT_W-1:0] want_setting = WANT_RESET;

  slot_report_t pending_reports[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int mismatches = 0;
  int reports_seen = 0;
  int points_sent = 0;
  int runs_sent = 0;

  k_nearest_point_selector_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .count_wanted(count_wanted),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .query_x(query_x),
    .query_y(query_y),
    .query_z(query_z),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .first_point(first_point),
    .last_point(last_point),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rank(rank),
    .point_index(point_index),
    .distance_sq(distance_sq),
    .slot_valid(slot_valid),
    .found_count(found_count),
    .too_many_points(too_many_points),
    .last_result(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Empty the list and restart point numbering
  function automatic void clear_list();
    for (int j = 0; j < KEEP_MAX; j++) begin
      slot_sq[j] = SQ_EMPTY;
      slot_idx[j] = '0;
      slot_full[j] = 1'b0;
    end
    insert_cnt = 0;
    point_cnt = 0;
    overflow_flag = 1'b0;
  endfunction

  function automatic int keep_now();
    int k;
    k = want_setting;
    if (k < 1) k = 1;
    if (k > KEEP_MAX) k = KEEP_MAX;
    return k;
  endfunction

  function automatic longint unsigned axis_sq(coord_t q, coord_t p);
    longint diff;
    diff = longint'(q) - longint'(p);
    return diff * diff;
  endfunction

  // Insert one point into the sorted list; queue the report on a last mark
  function automatic void predict_point(point_t p);
    int k;
    longint unsigned sq;
    bit placed;
    slot_report_t rep;
    k = keep_now();
    if (p.first) clear_list();
    if (point_cnt >= NODE_LIMIT) begin
      overflow_flag = 1'b1;
    end else begin
      sq = axis_sq(p.qx, p.px) + axis_sq(p.qy, p.py) + axis_sq(p.qz, p.pz);
      if (sq > SQ_EMPTY) sq = SQ_EMPTY;
      placed = 1'b0;
      // zero distance never enters the list; ties keep the older point ahead
      if (sq != 0) begin
        for (int j = 0; j < k && !placed; j++) begin
          if (!slot_full[j] || sq < slot_sq[j]) begin
            for (int s = k - 1; s > j; s--) begin
              slot_sq[s] = slot_sq[s-1];
              slot_idx[s] = slot_idx[s-1];
              slot_full[s] = slot_full[s-1];
            end
            slot_sq[j] = DIST_W'(sq);
            slot_idx[j] = IDX_W'(point_cnt);
            slot_full[j] = 1'b1;
            insert_cnt++;
            if (insert_cnt > k) insert_cnt = k;
            placed = 1'b1;
          end
        end
      end
      point_cnt++;
    end
    if (p.last) begin
      for (int j = 0; j < k; j++) begin
        rep.rank = RANK_W'(j);
        rep.idx = slot_full[j] ? slot_idx[j] : '0;
        rep.sq = slot_full[j] ? slot_sq[j] : '0;
        rep.full = slot_full[j];
        rep.found = FOUND_W'((insert_cnt < k) ? insert_cnt : k);
        rep.over = overflow_flag;
        rep.last = (j == k - 1);
        pending_reports.push_back(rep);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_report();
    slot_report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t  unexpected result word: rank %0d index %0d distance %0d",
               $time, rank, point_index, distance_sq);
      mismatches++;
    end else begin
      want = pending_reports.pop_front();
      check_field("rank", want.rank, rank);
      check_field("point_index", want.idx, point_index);
      check_field("distance_sq", want.sq, distance_sq);
      check_field("slot_valid", want.full, slot_valid);
      check_field("found_count", want.found, found_count);
      check_field("too_many_points", want.over, too_many_points);
      check_field("last_result", want.last, last_result);
      reports_seen++;
    end
  endfunction

  // Take result words; stall at random or for a forced hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_report();
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("%0t  timeout: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("** k_nearest_point_selector_core: FAILED **");
      $finish;
    end
  end

  function automatic point_t make_point(coord_t qx, coord_t qy, coord_t qz,
                                        coord_t px, coord_t py, coord_t pz,
                                        bit first, bit last);
    point_t p;
    p.qx = qx; p.qy = qy; p.qz = qz;
    p.px = px; p.py = py; p.pz = pz;
    p.first = first;
    p.last = last;
    return p;
  endfunction

  function automatic coord_t rand_query();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? C_MAX : C_MIN;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Candidate coordinate: mostly close to the query so ties and reorders happen
  function automatic coord_t near_coord(coord_t base);
    int offs;
    offs = int'($urandom_range(16)) - 8;
    case ($urandom_range(9))
      0: return $urandom_range(1) ? C_MAX : C_MIN;
      1, 2, 3: return coord_t'($urandom);
      4, 5, 6, 7: return coord_t'(base + offs);
      8: return base;
      default: return base ^ (coord_t'(1) << $urandom_range(COORD_W - 1));
    endcase
  endfunction

  // Offer one point word; keep valid high into the next word unless a gap is drawn
  task automatic send_point(point_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    query_x <= p.qx;
    query_y <= p.qy;
    query_z <= p.qz;
    point_x <= p.px;
    point_y <= p.py;
    point_z <= p.pz;
    first_point <= p.first;
    last_point <= p.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_point(p);
    points_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every queued result has arrived, then let the pipeline settle
  task automatic wait_drained(int extra);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_keep(int value);
    stop_sending();
    wait_drained(DRAIN_CYCLES);
    count_wanted <= WANT_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    want_setting = WANT_W'(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Report straight out of reset, without a first mark
  task automatic test_reset_state();
    send_point(make_point(0, 0, 0, -1, -1, -1, 1'b0, 1'b1));
    runs_sent++;
  endtask

  // Zero distance, largest distance both ways, one LSB, ties, bit patterns
  task automatic test_extremes();
    send_point(make_point(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, coord_t'(C_MAX - 1), C_MAX, C_MAX,
                          1'b0, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, coord_t'(C_MAX - 2), C_MAX, C_MAX,
                          1'b0, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, C_MAX, coord_t'(C_MAX - 2), C_MAX,
                          1'b0, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, 20'sh55555, 20'shAAAAA, 20'sh55555,
                          1'b0, 1'b0));
    send_point(make_point(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, coord_t'(C_MAX - 2),
                          1'b0, 1'b1));
    send_point(make_point(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1));
    runs_sent += 2;
  endtask

  // Keep size of zero acts as one, above the list size acts as the full list
  task automatic test_keep_limits();
    set_keep(0);
    for (int i = 0; i < 3; i++)
      send_point(make_point(0, 0, 0, coord_t'($urandom), coord_t'($urandom),
                            coord_t'($urandom), i == 0, i == 2));
    set_keep(31);
    for (int i = 0; i < 5; i++)
      send_point(make_point(0, 0, 0, coord_t'($urandom), coord_t'($urandom),
                            coord_t'($urandom), i == 0, i == 4));
    runs_sent += 2;
  endtask

  // Change the keep size inside a run; slots past it keep their contents
  task automatic test_keep_change_mid_run();
    set_keep(3);
    send_point(make_point(0, 0, 0, 3, 0, 0, 1'b1, 1'b0));
    send_point(make_point(0, 0, 0, 0, 4, 0, 1'b0, 1'b0));
    send_point(make_point(0, 0, 0, 0, 0, 5, 1'b0, 1'b0));
    send_point(make_point(0, 0, 0, 6, 0, 0, 1'b0, 1'b0));
    set_keep(10);
    send_point(make_point(0, 0, 0, 0, 0, 2, 1'b0, 1'b1));
    set_keep(2);
    send_point(make_point(0, 0, 0, 0, 1, 0, 1'b0, 1'b1));
    set_keep(10);
    send_point(make_point(0, 0, 0, 7, 0, 0, 1'b0, 1'b1));
    runs_sent += 3;
  endtask

  // Hold the output off so the report backs up and the input stalls
  task automatic test_backpressure();
    coord_t q;
    set_keep(16);
    q = rand_query();
    hold_left = HOLD_OFF;
    for (int r = 0; r < 2; r++)
      for (int i = 0; i < 6; i++)
        send_point(make_point(q, q, q, near_coord(q), near_coord(q), near_coord(q),
                              i == 0, i == 5));
    runs_sent += 2;
    stop_sending();
    wait_drained(DRAIN_CYCLES);
  endtask

  // Mostly well-formed runs with random content; some lack a first or last mark
  task automatic test_random_runs(int count);
    point_t p;
    coord_t qx, qy, qz;
    int len;
    int done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(9))
          0: set_keep(0);
          1: set_keep($urandom_range(31, 17));
          2: set_keep(KEEP_MAX);
          3: set_keep(1);
          default: set_keep($urandom_range(15, 2));
        endcase
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      qx = rand_query();
      qy = rand_query();
      qz = rand_query();
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) qx = rand_query();
        p.qx = qx;
        p.qy = qy;
        p.qz = qz;
        if ($urandom_range(24) == 0) begin
          p.px = qx;
          p.py = qy;
          p.pz = qz;
        end else begin
          p.px = near_coord(qx);
          p.py = near_coord(qy);
          p.pz = near_coord(qz);
        end
        p.first = (i == 0) && ($urandom_range(9) != 0);
        p.last = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
        send_point(p);
      end
      done += len;
      runs_sent++;
    end
  endtask

  initial begin
    clear_list();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_extremes();
    test_keep_limits();
    test_keep_change_mid_run();
    test_backpressure();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_runs(100);
    send_idle_pct = 82;
    recv_stall_pct = 0;
    test_random_runs(100);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    test_random_runs(100);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random_runs(100);

    stop_sending();
    wait_drained(END_CYCLES);
    if (pending_reports.size() != 0) begin
      $display("%0t  result words missing: expected %0d more, actual 0",
               $time, pending_reports.size());
      mismatches++;
    end

    $display("Summary: %0d point words in %0d runs, %0d result words checked, %0d mismatches",
             points_sent, runs_sent, reports_seen, mismatches);
    $display("Covered: keep sizes 0 to 31, ties, zero distance, keep changes, stalls");
    if (mismatches == 0) begin
      $display("** k_nearest_point_selector_core: PASSED **");
    end else begin
      $display("** k_nearest_point_selector_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
